// ===== sv/tpi_pkg.sv =====
// shared types and widths for the three plane intersection core
`timescale 1ns / 1ps

package tpi_pkg;

  localparam int DMAG_W = 48;
  localparam int QUO_W  = 33;
  localparam int DIV_STEPS = QUO_W;

  typedef struct packed {
    logic signed [15:0] normal_a_x;
    logic signed [15:0] normal_a_y;
    logic signed [15:0] normal_a_z;
    logic signed [31:0] offset_a;
    logic signed [15:0] normal_b_x;
    logic signed [15:0] normal_b_y;
    logic signed [15:0] normal_b_z;
    logic signed [31:0] offset_b;
    logic signed [15:0] normal_c_x;
    logic signed [15:0] normal_c_y;
    logic signed [15:0] normal_c_z;
    logic signed [31:0] offset_c;
  } in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic              ovf;
    logic              neg;
    logic [DMAG_W-1:0] rem;
    logic [QUO_W-1:0]  sh;
  } coord_t;

  typedef struct packed {
    logic              found;
    logic [DMAG_W-1:0] dmag;
    coord_t [2:0]      c;
  } div_t;

endpackage

// ===== sv/tpi_front.sv =====
// cross products, triple product, numerators and divider setup, six stages
`timescale 1ns / 1ps

module tpi_front import tpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_hold,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_hold,
  output div_t out_data
);

  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  logic signed [31:0] s1_pl [9];
  logic signed [31:0] s1_pr [9];
  logic signed [15:0] s1_na [3];
  logic signed [31:0] s1_off [3];

  logic signed [32:0] s2_cr [9];
  logic signed [15:0] s2_na [3];
  logic signed [31:0] s2_off [3];

  logic signed [48:0] s3_tri [3];
  logic signed [64:0] s3_p [9];

  logic signed [50:0] s4_tsum;
  logic signed [65:0] s4_nsum [3];

  logic              s5_found;
  logic              s5_den_neg;
  logic [DMAG_W-1:0] s5_dmag;
  logic              s5_num_neg [3];
  logic [63:0]       s5_nmag [3];

  logic signed [50:0] tabs;
  logic signed [65:0] nabs [3];
  logic [77:0]        nshift [3];
  logic [DMAG_W-1:0]  nhi [3];
  div_t               s6;

  assign en6 = !v6 || !out_hold;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_hold = !en1;
  assign out_valid = v6;
  assign out_data = s6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // stage 1: the eighteen normal products
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pl[0] <= in_data.normal_b_y * in_data.normal_c_z;
      s1_pr[0] <= in_data.normal_b_z * in_data.normal_c_y;
      s1_pl[1] <= in_data.normal_b_z * in_data.normal_c_x;
      s1_pr[1] <= in_data.normal_b_x * in_data.normal_c_z;
      s1_pl[2] <= in_data.normal_b_x * in_data.normal_c_y;
      s1_pr[2] <= in_data.normal_b_y * in_data.normal_c_x;
      s1_pl[3] <= in_data.normal_c_y * in_data.normal_a_z;
      s1_pr[3] <= in_data.normal_c_z * in_data.normal_a_y;
      s1_pl[4] <= in_data.normal_c_z * in_data.normal_a_x;
      s1_pr[4] <= in_data.normal_c_x * in_data.normal_a_z;
      s1_pl[5] <= in_data.normal_c_x * in_data.normal_a_y;
      s1_pr[5] <= in_data.normal_c_y * in_data.normal_a_x;
      s1_pl[6] <= in_data.normal_a_y * in_data.normal_b_z;
      s1_pr[6] <= in_data.normal_a_z * in_data.normal_b_y;
      s1_pl[7] <= in_data.normal_a_z * in_data.normal_b_x;
      s1_pr[7] <= in_data.normal_a_x * in_data.normal_b_z;
      s1_pl[8] <= in_data.normal_a_x * in_data.normal_b_y;
      s1_pr[8] <= in_data.normal_a_y * in_data.normal_b_x;
      s1_na[0] <= in_data.normal_a_x;
      s1_na[1] <= in_data.normal_a_y;
      s1_na[2] <= in_data.normal_a_z;
      s1_off[0] <= in_data.offset_a;
      s1_off[1] <= in_data.offset_b;
      s1_off[2] <= in_data.offset_c;
    end
  end

  // stage 2: cross products bc, ca, ab
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int j = 0; j < 9; j++) begin
        s2_cr[j] <= 33'(s1_pl[j]) - 33'(s1_pr[j]);
      end
      s2_na <= s1_na;
      s2_off <= s1_off;
    end
  end

  // stage 3: triple and numerator partial products
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int k = 0; k < 3; k++) begin
        s3_tri[k] <= s2_na[k] * s2_cr[k];
      end
      for (int m = 0; m < 3; m++) begin
        for (int k = 0; k < 3; k++) begin
          s3_p[3*m+k] <= s2_off[m] * s2_cr[3*m+k];
        end
      end
    end
  end

  // stage 4: sums
  always_ff @(posedge clk) begin
    if (en4) begin
      s4_tsum <= 51'(s3_tri[0]) + 51'(s3_tri[1]) + 51'(s3_tri[2]);
      for (int k = 0; k < 3; k++) begin
        s4_nsum[k] <= 66'(s3_p[k]) + 66'(s3_p[3+k]) + 66'(s3_p[6+k]);
      end
    end
  end

  // stage 5: signs and magnitudes
  always_comb begin
    tabs = s4_tsum[50] ? -s4_tsum : s4_tsum;
    for (int k = 0; k < 3; k++) begin
      nabs[k] = s4_nsum[k][65] ? -s4_nsum[k] : s4_nsum[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_found <= (s4_tsum != '0);
      s5_den_neg <= s4_tsum[50];
      s5_dmag <= tabs[DMAG_W-1:0];
      for (int k = 0; k < 3; k++) begin
        s5_num_neg[k] <= s4_nsum[k][65];
        s5_nmag[k] <= nabs[k][63:0];
      end
    end
  end

  // stage 6: overflow check against dmag * 2^33 and remainder setup
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nshift[k] = {s5_nmag[k], 14'b0};
      nhi[k] = {3'b0, nshift[k][77:QUO_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6.found <= s5_found;
      s6.dmag <= s5_dmag;
      for (int k = 0; k < 3; k++) begin
        s6.c[k].ovf <= (nhi[k] >= s5_dmag);
        s6.c[k].neg <= (s5_num_neg[k] == s5_den_neg);
        s6.c[k].rem <= (nhi[k] >= s5_dmag) ? '0 : nhi[k];
        s6.c[k].sh <= nshift[k][QUO_W-1:0];
      end
    end
  end

endmodule

// ===== sv/tpi_div_step.sv =====
// one restoring division step for the three coordinates, one register stage
`timescale 1ns / 1ps

module tpi_div_step import tpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_hold,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_hold,
  output div_t out_data
);

  logic            v;
  logic            en;
  div_t            stage;
  div_t            nxt;
  logic [DMAG_W:0] r2 [3];
  logic            ge [3];

  assign en = !v || !out_hold;
  assign in_hold = !en;
  assign out_valid = v;
  assign out_data = stage;

  always_comb begin
    nxt = in_data;
    for (int k = 0; k < 3; k++) begin
      r2[k] = {in_data.c[k].rem, in_data.c[k].sh[QUO_W-1]};
      ge[k] = (r2[k] >= {1'b0, in_data.dmag});
      nxt.c[k].rem = ge[k] ? DMAG_W'(r2[k] - {1'b0, in_data.dmag}) : r2[k][DMAG_W-1:0];
      nxt.c[k].sh = {in_data.c[k].sh[QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= nxt;
    end
  end

endmodule

// ===== sv/tpi_divider.sv =====
// chain of division steps giving the quotient bits
`timescale 1ns / 1ps

module tpi_divider import tpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_hold,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_hold,
  output div_t out_data
);

  logic vld  [DIV_STEPS+1];
  logic hold [DIV_STEPS+1];
  div_t dat  [DIV_STEPS+1];

  assign vld[0] = in_valid;
  assign dat[0] = in_data;
  assign in_hold = hold[0];
  assign out_valid = vld[DIV_STEPS];
  assign out_data = dat[DIV_STEPS];
  assign hold[DIV_STEPS] = out_hold;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    tpi_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_hold   (hold[i]),
      .in_data   (dat[i]),
      .out_valid (vld[i+1]),
      .out_hold  (hold[i+1]),
      .out_data  (dat[i+1])
    );
  end

endmodule

// ===== sv/tpi_back.sv =====
// rounding, saturation and sign, two stages ending in the output register
`timescale 1ns / 1ps

module tpi_back import tpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_hold,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_hold,
  output out_t out_data
);

  logic        va, vb;
  logic        ena, enb;
  logic        a_found;
  logic        a_ovf [3];
  logic        a_neg [3];
  logic [33:0] a_q [3];
  logic [33:0] limit [3];
  logic        sat [3];
  logic [31:0] mag [3];
  logic [31:0] val [3];
  out_t        res;

  assign enb = !vb || !out_hold;
  assign ena = !va || enb;
  assign in_hold = !ena;
  assign out_valid = vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ena) va <= in_valid;
      if (enb) vb <= va;
    end
  end

  // round to nearest, ties away from zero
  always_ff @(posedge clk) begin
    if (ena) begin
      a_found <= in_data.found;
      for (int k = 0; k < 3; k++) begin
        a_ovf[k] <= in_data.c[k].ovf;
        a_neg[k] <= in_data.c[k].neg;
        a_q[k] <= {1'b0, in_data.c[k].sh}
                  + 34'(({in_data.c[k].rem, 1'b0} >= {1'b0, in_data.dmag}));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      limit[k] = a_neg[k] ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
      sat[k] = a_ovf[k] || (a_q[k] > limit[k]);
      mag[k] = sat[k] ? limit[k][31:0] : a_q[k][31:0];
      val[k] = a_neg[k] ? (32'd0 - mag[k]) : mag[k];
    end
    res.found = a_found;
    res.point_x = a_found ? val[0] : '0;
    res.point_y = a_found ? val[1] : '0;
    res.point_z = a_found ? val[2] : '0;
    res.saturated = a_found && (sat[0] || sat[1] || sat[2]);
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      out_data <= res;
    end
  end

endmodule

// ===== sv/three_plane_intersection_core.sv =====
// top level of the three plane intersection core
//
// takes three planes (normal in signed Q2.14, intercept in signed Q16.16)
// per input transfer and returns one result per input: the common point in
// signed Q16.16, rounded to nearest and saturated, with found and saturated
// flags. found is low and the point is zero when the normals are dependent.
// both channels use valid and stall; a transfer happens when valid is high
// and stall is low.
// from input transfer to output valid an item passes six stages of
// products, sums and setup, 33 restoring division stages (one quotient bit
// each) and two stages of rounding and saturation. throughput is one item
// per cycle while out_stall is low; every stage holds its own valid bit.
// when the receiver stalls, the output register holds its result and the
// stages behind it keep filling bubbles; input stall rises only once every
// stage holds an item.
// reset clears all valid bits; no result is in flight afterwards.
`timescale 1ns / 1ps

module three_plane_intersection_core import tpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic f_valid, f_hold;
  div_t f_data;
  logic d_valid, d_hold;
  div_t d_data;

  tpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_hold   (in_stall),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_hold  (f_hold),
    .out_data  (f_data)
  );

  tpi_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_hold   (f_hold),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_hold  (d_hold),
    .out_data  (d_data)
  );

  tpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_hold   (d_hold),
    .in_data   (d_data),
    .out_valid (out_valid),
    .out_hold  (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/tpi_checker.sv =====
// port level checks for the three plane intersection core
`timescale 1ns / 1ps

module tpi_checker import tpi_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transfer changed");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transfer changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.point_x == 0 && out_data.point_y == 0
      && out_data.point_z == 0 && !out_data.saturated)
    else $error("nonzero result without intersection");

  a_no_stall_when_draining: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind three_plane_intersection_core tpi_checker u_tpi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/three_plane_intersection_core_tb.sv =====
// self-checking testbench for the three plane intersection core
`timescale 1ns / 1ps

module three_plane_intersection_core_tb;
  import tpi_pkg::*;

  class point_scoreboard;
    out_t pending[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function out_t solve_point(in_t p);
      logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz, da, db, dc;
      logic signed [63:0] bc[3], ca[3], ab[3];
      logic signed [63:0] tri_p;
      logic signed [127:0] num;
      logic [127:0] nmag, q;
      logic [63:0] dmag, r;
      logic neg;
      logic [31:0] lim;
      logic [31:0] crd[3];
      out_t res;
      ax = p.normal_a_x; ay = p.normal_a_y; az = p.normal_a_z; da = p.offset_a;
      bx = p.normal_b_x; by = p.normal_b_y; bz = p.normal_b_z; db = p.offset_b;
      cx = p.normal_c_x; cy = p.normal_c_y; cz = p.normal_c_z; dc = p.offset_c;
      bc[0] = by * cz - bz * cy; bc[1] = bz * cx - bx * cz; bc[2] = bx * cy - by * cx;
      ca[0] = cy * az - cz * ay; ca[1] = cz * ax - cx * az; ca[2] = cx * ay - cy * ax;
      ab[0] = ay * bz - az * by; ab[1] = az * bx - ax * bz; ab[2] = ax * by - ay * bx;
      tri_p = ax * bc[0] + ay * bc[1] + az * bc[2];
      res = '0;
      if (tri_p == 0) return res;
      res.found = 1'b1;
      dmag = tri_p < 0 ? -tri_p : tri_p;
      for (int k = 0; k < 3; k++) begin
        num = 128'(signed'(da * bc[k])) + 128'(signed'(db * ca[k]))
              + 128'(signed'(dc * ab[k]));
        num = num <<< 14;
        nmag = num < 0 ? -num : num;
        q = nmag / dmag;
        r = 64'(nmag % dmag);
        if ({r, 1'b0} >= {1'b0, dmag}) q = q + 1;
        neg = (num < 0) == (tri_p < 0);
        lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        if (q > {96'd0, lim}) begin
          res.saturated = 1'b1;
          q = {96'd0, lim};
        end
        crd[k] = neg ? -q[31:0] : q[31:0];
      end
      res.point_x = crd[0]; res.point_y = crd[1]; res.point_z = crd[2];
      return res;
    endfunction

    function void note_input(in_t p);
      pending.push_back(solve_point(p));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found || got.point_x !== want.point_x ||
          got.point_y !== want.point_y || got.point_z !== want.point_z ||
          got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected f=%b x=%h y=%h z=%h s=%b got f=%b x=%h y=%h z=%h s=%b",
                   want.found, want.point_x, want.point_y, want.point_z, want.saturated,
                   got.found, got.point_x, got.point_y, got.point_z, got.saturated);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;

  point_scoreboard board = new();
  int idle_cycles = 0;
  bit timed_out = 0;
  bit stall_on = 0;

  three_plane_intersection_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
    if (!rst && in_valid && !in_stall) board.note_input(in_data);
  end

  // receiver stall pattern: alternating runs, sometimes long quiet stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
    out_stall <= stall_on ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] pick_normal();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_planes();
    in_t p;
    p.normal_a_x = pick_normal(); p.normal_a_y = pick_normal(); p.normal_a_z = pick_normal();
    p.normal_b_x = pick_normal(); p.normal_b_y = pick_normal(); p.normal_b_z = pick_normal();
    p.normal_c_x = pick_normal(); p.normal_c_y = pick_normal(); p.normal_c_z = pick_normal();
    p.offset_a = pick_offset(); p.offset_b = pick_offset(); p.offset_c = pick_offset();
    // dependent normals now and then
    case ($urandom_range(0, 7))
      0: {p.normal_c_x, p.normal_c_y, p.normal_c_z} =
           {p.normal_a_x, p.normal_a_y, p.normal_a_z};
      1: {p.normal_b_x, p.normal_b_y, p.normal_b_z} = '0;
      default: ;
    endcase
    return p;
  endfunction

  // one transfer: valid held until accepted
  task automatic send_planes(in_t p);
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic in_t planes_of(logic [15:0] n, logic [31:0] d);
    in_t p;
    p = '0;
    p.normal_a_x = n; p.normal_b_y = n; p.normal_c_z = n;
    p.offset_a = d; p.offset_b = d; p.offset_c = d;
    return p;
  endfunction

  initial begin
    in_t p;
    int burst;
    int sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: axis planes at extremes, zero and dependent normals, saturation
    send_planes(planes_of(16'h4000, 32'h0001_0000));
    send_planes(planes_of(16'h7fff, 32'h7fff_ffff));
    send_planes(planes_of(16'h8000, 32'h8000_0000));
    send_planes(planes_of(16'h0001, 32'h7fff_ffff));
    send_planes(planes_of(16'hffff, 32'h8000_0000));
    send_planes(planes_of(16'h0001, 32'h0000_0001));
    send_planes(planes_of(16'h0003, 32'h0000_0001));
    send_planes(planes_of(16'h0000, 32'h1234_5678));
    send_planes('0);
    send_planes('1);
    p = planes_of(16'h4000, 32'h0002_0000);
    p.normal_c_z = 16'h0;
    send_planes(p);
    p = random_planes();
    {p.normal_b_x, p.normal_b_y, p.normal_b_z} = {p.normal_a_x, p.normal_a_y, p.normal_a_z};
    send_planes(p);
    for (int i = 0; i < 8; i++) begin
      p = '1;
      p.normal_a_x = 16'h8000; p.normal_b_y = 16'h7fff; p.normal_c_z = 16'h8000;
      p.offset_a = $urandom; p.offset_b = $urandom; p.offset_c = $urandom;
      send_planes(p);
    end
    send_gap();
    sent = 0;
    while (sent < 950) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) begin
        send_planes(random_planes());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/tpi_pkg.sv
sv/tpi_front.sv
sv/tpi_div_step.sv
sv/tpi_divider.sv
sv/tpi_back.sv
sv/three_plane_intersection_core.sv
sv/tpi_checker.sv
tb/three_plane_intersection_core_tb.sv
